### hw/rtl/rcpa_pkg.sv
// Shared types and constants of the page allocator.
// No dependencies; every other file imports this package.
package rcpa_pkg;

    localparam int unsigned NUM_PAGES      = 32768;
    localparam int unsigned PAGES_PER_SLOT = 512;
    localparam int unsigned NUM_SLOTS      = 64;

    localparam int unsigned PAGE_W = 15;
    localparam int unsigned LINK_W = 16;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned SLOT_W = 6;
    localparam int unsigned OFF_W  = 9;
    localparam int unsigned J_W    = OFF_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        M_DONATE     = 3'd0,
        M_ALLOC      = 3'd1,
        M_FREE       = 3'd2,
        M_INCREF     = 3'd3,
        M_SUPERALLOC = 3'd4,
        M_SUPERFREE  = 3'd5,
        M_SINCREF    = 3'd6,
        M_NOP        = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OOM      = 3'd1,
        ST_BADADDR  = 3'd2,
        ST_UNDER    = 3'd3,
        ST_CONFLICT = 3'd4,
        ST_OVER     = 3'd5
    } t_status;

    // Command from controller to datapath.
    typedef struct packed {
        logic [PAGE_W-1:0] pref_raddr;
        logic              pref_we;
        logic [PAGE_W-1:0] pref_waddr;
        logic [CNT_W-1:0]  pref_wdata;
        logic [SLOT_W-1:0] sref_raddr;
        logic              sref_we;
        logic [SLOT_W-1:0] sref_waddr;
        logic [CNT_W-1:0]  sref_wdata;
        logic [PAGE_W-1:0] next_raddr;
        logic              next_we;
        logic [PAGE_W-1:0] next_waddr;
        logic [LINK_W-1:0] next_wdata;
        logic [PAGE_W-1:0] prev_raddr;
        logic              prev_we;
        logic [PAGE_W-1:0] prev_waddr;
        logic [LINK_W-1:0] prev_wdata;
        logic              head_we;
        logic [LINK_W-1:0] head_wdata;
    } t_cmd;

    // Status from datapath to controller; read data is registered and appears in the cycle after the address.
    typedef struct packed {
        logic [CNT_W-1:0]  pref_rdata;
        logic [CNT_W-1:0]  sref_rdata;
        logic [LINK_W-1:0] next_rdata;
        logic [LINK_W-1:0] prev_rdata;
        logic [LINK_W-1:0] head;
    } t_sts;

endpackage

### hw/rtl/rcpa_ifs.sv
// Request and result channel interfaces of the page allocator.
// Depends on rcpa_pkg for field widths.
interface rcpa_in_if;
    import rcpa_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        mode;
    logic [PAGE_W-1:0] page_index;
    modport source (output valid, mode, page_index, input ready);
    modport sink   (input valid, mode, page_index, output ready);
endinterface

interface rcpa_out_if;
    import rcpa_pkg::*;
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] result_page;
    logic [2:0]        status;
    modport source (output valid, result_page, status, input ready);
    modport sink   (input valid, result_page, status, output ready);
endinterface

### hw/rtl/refcounted_page_and_superpage_allocator_unit.sv
// Reference-counted page and superpage allocator: top level with APB register.
// Depends on rcpa_pkg, rcpa_ifs, rcpa_ctrl and rcpa_dpath.
//
// One request (mode, page_index) gives one result (result_page, status). Requests are
// handled one at a time by a controller stepping over single-port-write memories for the
// links and counts. After reset a clearing pass zeroes the page and slot counts; no request
// is taken during it, while configuration writes are taken as ever. Donate and free check
// the address and alloc the list head; then the page and slot counts are read and updated,
// and a donate, or a free that drops the page count to zero, pushes the page onto the free
// list. Sincref makes one scan pass and one read-modify-write pass over the slot; superfree
// does the same and, when the slot count reaches zero, puts the slot's pages back on the
// free list. Superalloc searches the slots for a zero count, scans the slot it finds, then
// unlinks each of its pages from the free list. Each memory port handles one entry per
// cycle. The result register lets the next request enter while a result still waits.
// first_usable_page lies at byte address 0.
module refcounted_page_and_superpage_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcpa_in_if.sink     i_in,
    rcpa_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rcpa_pkg::*;

    logic [PAGE_W-1:0] r_first_usable;
    t_cmd              cmd;
    t_sts              sts;

    // Register 0 is selected by address bit 2; the low two bits address bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_usable <= '0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_first_usable <= pwdata[PAGE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : 32'(r_first_usable);

    rcpa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_first_usable (r_first_usable),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (i_in.ready),
        .i_mode         (i_in.mode),
        .i_page_index   (i_in.page_index),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_result_page  (o_out.result_page),
        .o_status       (o_out.status),
        .o_cmd          (cmd),
        .i_sts          (sts)
    );

    rcpa_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

### hw/rtl/rcpa_dpath.sv
// Datapath: link and count memories plus the free list head register.
// Depends on rcpa_pkg.
module rcpa_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rcpa_pkg::t_cmd i_cmd,
    output rcpa_pkg::t_sts o_sts
);
    import rcpa_pkg::*;

    logic [CNT_W-1:0]  pref_mem [NUM_PAGES];
    logic [CNT_W-1:0]  sref_mem [NUM_SLOTS];
    logic [LINK_W-1:0] next_mem [NUM_PAGES];
    logic [LINK_W-1:0] prev_mem [NUM_PAGES];

    logic [CNT_W-1:0]  r_pref_rd;
    logic [CNT_W-1:0]  r_sref_rd;
    logic [LINK_W-1:0] r_next_rd;
    logic [LINK_W-1:0] r_prev_rd;
    logic [LINK_W-1:0] r_head;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pref_we) begin
            pref_mem[i_cmd.pref_waddr] <= i_cmd.pref_wdata;
        end
        r_pref_rd <= pref_mem[i_cmd.pref_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sref_we) begin
            sref_mem[i_cmd.sref_waddr] <= i_cmd.sref_wdata;
        end
        r_sref_rd <= sref_mem[i_cmd.sref_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.next_we) begin
            next_mem[i_cmd.next_waddr] <= i_cmd.next_wdata;
        end
        r_next_rd <= next_mem[i_cmd.next_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prev_we) begin
            prev_mem[i_cmd.prev_waddr] <= i_cmd.prev_wdata;
        end
        r_prev_rd <= prev_mem[i_cmd.prev_raddr];
    end

    // Head holds page+1, zero when the list is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (i_cmd.head_we) begin
            r_head <= i_cmd.head_wdata;
        end
    end

    assign o_sts.pref_rdata = r_pref_rd;
    assign o_sts.sref_rdata = r_sref_rd;
    assign o_sts.next_rdata = r_next_rd;
    assign o_sts.prev_rdata = r_prev_rd;
    assign o_sts.head       = r_head;

endmodule

### hw/rtl/rcpa_ctrl.sv
// Controller: sequences every mode over the datapath memories and owns the result register.
// Depends on rcpa_pkg.
module rcpa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rcpa_pkg::PAGE_W-1:0] i_first_usable,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_mode,
    input  logic [rcpa_pkg::PAGE_W-1:0] i_page_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rcpa_pkg::PAGE_W-1:0] o_result_page,
    output logic [2:0]                  o_status,
    output rcpa_pkg::t_cmd              o_cmd,
    input  rcpa_pkg::t_sts              i_sts
);
    import rcpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_RD, S_ALLOC2, S_PUSH1, S_PUSH2, S_SRCH,
        S_SRCH2, S_CHK, S_PASS, S_UNL, S_UNL1, S_UNL2, S_FIN
    } t_state;

    localparam logic [J_W-1:0]   J_END    = J_W'(PAGES_PER_SLOT);
    localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(PAGES_PER_SLOT);
    localparam logic [CNT_W-1:0] SINC_MAX = CNT_MAX - SLOT_CNT;

    t_state            r_state;
    t_mode             r_mode;
    t_status           r_st;
    logic [PAGE_W-1:0] r_p;
    logic [J_W-1:0]    r_j;
    logic              r_vld;
    logic              r_bad;
    logic [SLOT_W-1:0] r_k;
    logic [PAGE_W-1:0] r_wa;
    logic [LINK_W-1:0] r_nx;
    logic [CNT_W-1:0]  r_sr;
    logic [PAGE_W-1:0] r_clr;
    logic [PAGE_W-1:0] r_res;
    logic              r_ovld;
    logic [PAGE_W-1:0] r_ores;
    t_status           r_ost;

    logic [SLOT_W-1:0] w_s;
    logic [PAGE_W-1:0] w_q;
    logic [LINK_W-1:0] w_q1;
    logic [PAGE_W-1:0] w_hm1;
    logic              w_scan_end;
    logic              w_last;

    assign w_s        = r_p[PAGE_W-1:OFF_W];
    assign w_q        = r_p | PAGE_W'(r_j[OFF_W-1:0]);
    assign w_q1       = LINK_W'(w_q) + 1'b1;
    assign w_hm1      = PAGE_W'(i_sts.head - 1'b1);
    assign w_scan_end = (r_j == J_END) && !r_vld;
    assign w_last     = (r_j[OFF_W-1:0] == '1);

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_ovld;
    assign o_result_page = r_ores;
    assign o_status      = r_ost;

    // Memory commands follow the state; they must match the branches below.
    always_comb begin
        o_cmd            = '0;
        o_cmd.pref_raddr = w_q;
        o_cmd.sref_raddr = w_s;
        o_cmd.next_raddr = w_q;
        o_cmd.prev_raddr = w_q;
        unique case (r_state)
            S_CLR: begin
                o_cmd.pref_we    = 1'b1;
                o_cmd.pref_waddr = r_clr;
                o_cmd.sref_we    = (r_clr < PAGE_W'(NUM_SLOTS));
                o_cmd.sref_waddr = r_clr[SLOT_W-1:0];
            end
            S_DEC: begin
                if (r_mode == M_ALLOC) begin
                    o_cmd.pref_raddr = w_hm1;
                    o_cmd.sref_raddr = w_hm1[PAGE_W-1:OFF_W];
                    o_cmd.next_raddr = w_hm1;
                end
            end
            S_RD: begin
                o_cmd.pref_waddr = r_p;
                o_cmd.sref_waddr = w_s;
                unique case (r_mode)
                    M_DONATE: begin
                        o_cmd.pref_we    = 1'b1;
                        o_cmd.pref_wdata = '0;
                        o_cmd.sref_we    = 1'b1;
                        o_cmd.sref_wdata = (i_sts.sref_rdata == '0) ? SLOT_CNT - 1'b1
                                                                    : i_sts.sref_rdata - 1'b1;
                    end
                    M_FREE: begin
                        if (i_sts.pref_rdata != '0 && i_sts.sref_rdata != '0) begin
                            o_cmd.pref_we    = 1'b1;
                            o_cmd.pref_wdata = i_sts.pref_rdata - 1'b1;
                            o_cmd.sref_we    = 1'b1;
                            o_cmd.sref_wdata = i_sts.sref_rdata - 1'b1;
                        end
                    end
                    M_ALLOC: begin
                        if (i_sts.sref_rdata != CNT_MAX) begin
                            o_cmd.sref_we    = 1'b1;
                            o_cmd.sref_wdata = i_sts.sref_rdata + 1'b1;
                            o_cmd.pref_we    = 1'b1;
                            o_cmd.pref_wdata = CNT_W'(1);
                            o_cmd.head_we    = 1'b1;
                            o_cmd.head_wdata = i_sts.next_rdata;
                            o_cmd.next_we    = 1'b1;
                            o_cmd.next_waddr = r_p;
                            o_cmd.next_wdata = '0;
                            o_cmd.prev_we    = (i_sts.next_rdata != '0);
                            o_cmd.prev_waddr = PAGE_W'(i_sts.next_rdata - 1'b1);
                            o_cmd.prev_wdata = '0;
                        end
                    end
                    M_INCREF: begin
                        if (i_sts.pref_rdata != CNT_MAX && i_sts.sref_rdata != CNT_MAX) begin
                            o_cmd.pref_we    = 1'b1;
                            o_cmd.pref_wdata = i_sts.pref_rdata + 1'b1;
                            o_cmd.sref_we    = 1'b1;
                            o_cmd.sref_wdata = i_sts.sref_rdata + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ALLOC2: begin
                o_cmd.prev_we    = 1'b1;
                o_cmd.prev_waddr = r_p;
                o_cmd.prev_wdata = '0;
            end
            S_PUSH1: begin
                o_cmd.next_we    = 1'b1;
                o_cmd.next_waddr = w_q;
                o_cmd.next_wdata = i_sts.head;
                o_cmd.prev_we    = 1'b1;
                o_cmd.prev_waddr = w_q;
                o_cmd.prev_wdata = '0;
                o_cmd.head_we    = 1'b1;
                o_cmd.head_wdata = w_q1;
            end
            S_PUSH2: begin
                o_cmd.prev_we    = 1'b1;
                o_cmd.prev_waddr = PAGE_W'(r_nx - 1'b1);
                o_cmd.prev_wdata = w_q1;
            end
            S_SRCH: begin
                o_cmd.sref_raddr = r_k;
            end
            S_CHK: begin
                o_cmd.sref_waddr = w_s;
                if (w_scan_end && !r_bad) begin
                    unique case (r_mode)
                        M_SUPERALLOC: begin
                            o_cmd.sref_we    = 1'b1;
                            o_cmd.sref_wdata = SLOT_CNT;
                        end
                        M_SUPERFREE: begin
                            o_cmd.sref_we    = (i_sts.sref_rdata >= SLOT_CNT);
                            o_cmd.sref_wdata = i_sts.sref_rdata - SLOT_CNT;
                        end
                        M_SINCREF: begin
                            o_cmd.sref_we    = (i_sts.sref_rdata <= SINC_MAX);
                            o_cmd.sref_wdata = i_sts.sref_rdata + SLOT_CNT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PASS: begin
                o_cmd.pref_we    = r_vld;
                o_cmd.pref_waddr = r_wa;
                o_cmd.pref_wdata = (r_mode == M_SUPERFREE) ? i_sts.pref_rdata - 1'b1
                                                           : i_sts.pref_rdata + 1'b1;
            end
            S_UNL1: begin
                o_cmd.pref_we    = 1'b1;
                o_cmd.pref_waddr = w_q;
                o_cmd.pref_wdata = CNT_W'(1);
                if (i_sts.prev_rdata != '0) begin
                    o_cmd.next_we    = 1'b1;
                    o_cmd.next_waddr = PAGE_W'(i_sts.prev_rdata - 1'b1);
                    o_cmd.next_wdata = i_sts.next_rdata;
                end else begin
                    o_cmd.head_we    = 1'b1;
                    o_cmd.head_wdata = i_sts.next_rdata;
                end
                o_cmd.prev_we    = (i_sts.next_rdata != '0);
                o_cmd.prev_waddr = PAGE_W'(i_sts.next_rdata - 1'b1);
                o_cmd.prev_wdata = i_sts.prev_rdata;
            end
            S_UNL2: begin
                o_cmd.next_we    = 1'b1;
                o_cmd.next_waddr = w_q;
                o_cmd.next_wdata = '0;
                o_cmd.prev_we    = 1'b1;
                o_cmd.prev_waddr = w_q;
                o_cmd.prev_wdata = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode  <= t_mode'(i_mode);
                        r_p     <= i_page_index;
                        r_j     <= '0;
                        r_res   <= '0;
                        r_st    <= ST_OK;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_vld <= 1'b0;
                    r_bad <= 1'b0;
                    unique case (r_mode)
                        M_DONATE, M_FREE: begin
                            if (r_p < i_first_usable) begin
                                r_st    <= ST_BADADDR;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                        M_ALLOC: begin
                            if (i_sts.head == '0) begin
                                r_st    <= ST_OOM;
                                r_state <= S_FIN;
                            end else begin
                                r_p     <= w_hm1;
                                r_state <= S_RD;
                            end
                        end
                        M_INCREF: r_state <= S_RD;
                        M_SUPERALLOC: begin
                            r_k     <= '0;
                            r_state <= S_SRCH;
                        end
                        M_SUPERFREE, M_SINCREF: begin
                            if (r_p[OFF_W-1:0] != '0) begin
                                r_st    <= ST_BADADDR;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_CHK;
                            end
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_RD: begin
                    unique case (r_mode)
                        M_DONATE: r_state <= S_PUSH1;
                        M_FREE: begin
                            if (i_sts.pref_rdata == '0 || i_sts.sref_rdata == '0) begin
                                r_st    <= ST_UNDER;
                                r_state <= S_FIN;
                            end else if (i_sts.pref_rdata == CNT_W'(1)) begin
                                r_state <= S_PUSH1;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                        M_ALLOC: begin
                            if (i_sts.sref_rdata == CNT_MAX) begin
                                r_st    <= ST_OVER;
                                r_state <= S_FIN;
                            end else begin
                                r_res   <= r_p;
                                r_state <= S_ALLOC2;
                            end
                        end
                        default: begin
                            if (i_sts.pref_rdata == CNT_MAX || i_sts.sref_rdata == CNT_MAX) begin
                                r_st <= ST_OVER;
                            end
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_ALLOC2: r_state <= S_FIN;
                S_PUSH1, S_PUSH2: begin
                    r_nx <= i_sts.head;
                    if (r_state == S_PUSH1 && i_sts.head != '0) begin
                        r_state <= S_PUSH2;
                    end else if (r_mode == M_SUPERFREE && !w_last) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_PUSH1;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SRCH: r_state <= S_SRCH2;
                S_SRCH2: begin
                    if (i_sts.sref_rdata == '0) begin
                        r_p     <= {r_k, OFF_W'(0)};
                        r_j     <= '0;
                        r_vld   <= 1'b0;
                        r_bad   <= 1'b0;
                        r_state <= S_CHK;
                    end else if (r_k == SLOT_W'(NUM_SLOTS - 1)) begin
                        r_st    <= ST_OOM;
                        r_state <= S_FIN;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SRCH;
                    end
                end
                S_CHK: begin
                    if (r_j != J_END) begin
                        r_j <= r_j + 1'b1;
                    end
                    r_vld <= (r_j != J_END);
                    if (r_vld) begin
                        priority case (r_mode)
                            M_SUPERALLOC: if (i_sts.pref_rdata != '0) r_bad <= 1'b1;
                            M_SUPERFREE:  if (i_sts.pref_rdata == '0) r_bad <= 1'b1;
                            default:      if (i_sts.pref_rdata == CNT_MAX) r_bad <= 1'b1;
                        endcase
                    end
                    if (w_scan_end) begin
                        r_j <= '0;
                        priority case (r_mode)
                            M_SUPERALLOC: begin
                                if (r_bad) begin
                                    r_st    <= ST_CONFLICT;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_UNL;
                                end
                            end
                            M_SUPERFREE: begin
                                r_sr <= i_sts.sref_rdata - SLOT_CNT;
                                if (r_bad || i_sts.sref_rdata < SLOT_CNT) begin
                                    r_st    <= ST_UNDER;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_PASS;
                                end
                            end
                            default: begin
                                if (r_bad || i_sts.sref_rdata > SINC_MAX) begin
                                    r_st    <= ST_OVER;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_PASS;
                                end
                            end
                        endcase
                    end
                end
                S_PASS: begin
                    if (r_j != J_END) begin
                        r_j <= r_j + 1'b1;
                    end
                    r_wa  <= w_q;
                    r_vld <= (r_j != J_END);
                    if (w_scan_end) begin
                        r_j <= '0;
                        if (r_mode == M_SUPERFREE && r_sr == '0) begin
                            r_state <= S_PUSH1;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_UNL:  r_state <= S_UNL1;
                S_UNL1: r_state <= S_UNL2;
                S_UNL2: begin
                    if (w_last) begin
                        r_res   <= r_p;
                        r_state <= S_FIN;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_UNL;
                    end
                end
                S_FIN: begin
                    if (!r_ovld || i_out_ready) begin
                        r_ovld  <= 1'b1;
                        r_ores  <= r_res;
                        r_ost   <= r_st;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_in_ready)
        else $error("request taken during clearing pass");

    a_result_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_ores != '0) |-> (r_ost == ST_OK))
        else $error("nonzero result page with error status");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK || r_state == S_PASS) |-> (r_j <= J_END))
        else $error("slot page index past end of slot");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_ovld) |=> (r_ovld && r_state == S_IDLE))
        else $error("finished item not loaded into output register");

endmodule
